>>> rtl/bresenham_line_stepper_defines.svh
// Assertion macros used by the RTL.
`ifndef BRESENHAM_LINE_STEPPER_DEFINES_SVH
`define BRESENHAM_LINE_STEPPER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define BLS_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("bls assertion failed");
`define BLS_ASSERT_ON(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("bls assertion failed");
`define BLS_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("bls assertion failed");
`else
`define BLS_ASSERT(label, prop)
`define BLS_ASSERT_ON(label, cond, prop)
`define BLS_ASSERT_NEXT(label, cond, prop)
`endif

`endif

>>> rtl/bls_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bls_pkg;

    localparam int COORD_BITS     = 16;
    localparam int REG_BITS       = 13;
    localparam int ADDR_BITS      = 24;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [REG_BITS-1:0] WIDTH_RESET  = REG_BITS'(1920);
    localparam logic [REG_BITS-1:0] HEIGHT_RESET = REG_BITS'(1080);

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_STEP = 1'b1
    } command_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_WINDOW_WIDTH  = 1'b0,
        REG_WINDOW_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        command_t                      command;
        logic signed [COORD_BITS-1:0]  start_x;
        logic signed [COORD_BITS-1:0]  start_y;
        logic signed [COORD_BITS-1:0]  end_x;
        logic signed [COORD_BITS-1:0]  end_y;
    } in_item_t;

    typedef struct packed {
        logic                          emitted;
        logic signed [COORD_BITS-1:0]  pixel_x;
        logic signed [COORD_BITS-1:0]  pixel_y;
        logic                          in_window;
        logic [ADDR_BITS-1:0]          pixel_address;
        logic                          last_pixel;
    } out_item_t;

    typedef struct packed {
        logic [REG_BITS-1:0] width;
        logic [REG_BITS-1:0] height;
    } win_cfg_t;

    typedef struct packed {
        logic      produce;
        out_item_t item;
    } step_out_t;

endpackage

`default_nettype wire

>>> rtl/bresenham_line_stepper.sv
`timescale 1ns / 1ps
`default_nettype none
// Bresenham line stepper.
// Input channel in_valid / in_stall / in_item: a load command latches two
// endpoints and returns nothing; a step command returns one result on
// out_valid / out_stall / out_item with the current pixel, its window flag,
// its frame-buffer address and a last flag, then advances one pixel.
// A step on a finished or empty line returns a result with emitted low.
// cfg_write / cfg_index / cfg_data set window width (index 0) and height
// (index 1); write only while the block is idle.
// A step result is registered in the output register, or the skid register.
// Throughput: one item per cycle while in_stall is low; the error update and
// next point take two compares and an add-subtract, the address one multiply.
// A two-entry output buffer (output register plus skid register) keeps input
// transfers going while a result waits; in_stall rises only once both hold.
// Reset clears the line state (current point equals end point, so the line is
// empty), empties the output buffer and sets the window to 1920 x 1080.
// While a result is stalled, out_item holds; at most one more step is taken.

`include "bresenham_line_stepper_defines.svh"

module bresenham_line_stepper (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire bls_pkg::in_item_t                    in_item,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output bls_pkg::out_item_t                        out_item,
    input  wire logic                                 cfg_write,
    input  wire logic [bls_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [bls_pkg::REG_BITS-1:0]         cfg_data
);

    bls_pkg::win_cfg_t  win_reg, win_next;
    bls_pkg::step_out_t core_result;
    bls_pkg::out_item_t out_item_reg, out_item_next;
    bls_pkg::out_item_t skid_item_reg, skid_item_next;
    logic               out_valid_reg, out_valid_next;
    logic               skid_valid_reg, skid_valid_next;
    logic               take, new_result, out_free;

    assign in_stall  = skid_valid_reg;
    assign take      = in_valid && !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    bls_step_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .item   (in_item),
        .win    (win_reg),
        .result (core_result)
    );

    always_comb
    begin
        win_next = win_reg;
        if (cfg_write)
        begin
            case (bls_pkg::cfg_reg_t'(cfg_index))
                bls_pkg::REG_WINDOW_WIDTH:  win_next.width  = cfg_data;
                bls_pkg::REG_WINDOW_HEIGHT: win_next.height = cfg_data;
                default:                    win_next = win_reg;
            endcase
        end
    end

    // advance the output buffer; drain skid first
    always_comb
    begin
        new_result      = take && core_result.produce;
        out_free        = !out_valid_reg || !out_stall;
        out_valid_next  = out_valid_reg;
        out_item_next   = out_item_reg;
        skid_valid_next = skid_valid_reg;
        skid_item_next  = skid_item_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_item_next   = skid_item_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = new_result;
                out_item_next  = core_result.item;
            end
        end
        else if (new_result)
        begin
            skid_valid_next = 1'b1;
            skid_item_next  = core_result.item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg.width  <= bls_pkg::WIDTH_RESET;
            win_reg.height <= bls_pkg::HEIGHT_RESET;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            win_reg        <= win_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg  <= out_item_next;
        skid_item_reg <= skid_item_next;
    end

    `BLS_ASSERT_ON(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    `BLS_ASSERT_NEXT(a_skid_holds, skid_valid_reg && out_stall, skid_valid_reg)
    `BLS_ASSERT_NEXT(a_load_no_result,
                     take && !out_valid_reg && in_item.command == bls_pkg::CMD_LOAD,
                     !out_valid_reg)
    `BLS_ASSERT_NEXT(a_step_result,
                     take && !out_valid_reg && in_item.command == bls_pkg::CMD_STEP,
                     out_valid_reg)
    `BLS_ASSERT_ON(a_empty_is_zero,
                   out_valid_reg && !out_item_reg.emitted,
                   out_item_reg.pixel_address == '0 && !out_item_reg.in_window &&
                   !out_item_reg.last_pixel)

endmodule

`default_nettype wire

>>> rtl/bls_step_core.sv
`timescale 1ns / 1ps
`default_nettype none

module bls_step_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              take,
    input  wire bls_pkg::in_item_t item,
    input  wire bls_pkg::win_cfg_t win,
    output bls_pkg::step_out_t     result
);

    localparam int CB   = bls_pkg::COORD_BITS;
    localparam int RB   = bls_pkg::REG_BITS;
    localparam int AB   = bls_pkg::ADDR_BITS;
    localparam int DB   = CB + 1;
    localparam int EB   = CB + 2;
    localparam int XB   = CB + 3;
    localparam int PB   = CB + RB;
    localparam int CMPB = (CB > RB) ? CB : RB;

    localparam logic [CB-1:0] ONE       = CB'(1);
    localparam logic [CB-1:0] MINUS_ONE = '1;

    logic signed [CB-1:0] cur_x_reg, cur_x_next;
    logic signed [CB-1:0] cur_y_reg, cur_y_next;
    logic signed [CB-1:0] goal_x_reg, goal_x_next;
    logic signed [CB-1:0] goal_y_reg, goal_y_next;
    logic [CB-1:0]        abs_dx_reg, abs_dx_next;
    logic [CB-1:0]        abs_dy_reg, abs_dy_next;
    logic signed [EB-1:0] err_reg, err_next;
    logic                 x_neg_reg, x_neg_next;
    logic                 y_neg_reg, y_neg_next;

    logic signed [DB-1:0] dx_full, dy_full, dx_mag, dy_mag;
    logic [CB-1:0]        abs_dx_load, abs_dy_load;
    logic signed [XB-1:0] e2, dx_x, dy_x, err_w;
    logic                 step_x, step_y, at_goal, in_win, x_ok, y_ok;
    logic [CB-1:0]        nx, ny;
    logic [PB-1:0]        prod;
    logic [AB-1:0]        addr;

    // load setup
    always_comb
    begin
        dx_full     = DB'(item.end_x) - DB'(item.start_x);
        dy_full     = DB'(item.end_y) - DB'(item.start_y);
        dx_mag      = dx_full[DB-1] ? -dx_full : dx_full;
        dy_mag      = dy_full[DB-1] ? -dy_full : dy_full;
        abs_dx_load = dx_mag[CB-1:0];
        abs_dy_load = dy_mag[CB-1:0];
    end

    // doubled-error step
    always_comb
    begin
        at_goal = (cur_x_reg == goal_x_reg) && (cur_y_reg == goal_y_reg);
        e2      = {err_reg, 1'b0};
        dx_x    = $signed(XB'(abs_dx_reg));
        dy_x    = $signed(XB'(abs_dy_reg));
        step_x  = e2 > -dy_x;
        step_y  = e2 < dx_x;
        err_w   = XB'(err_reg) - (step_x ? dy_x : '0) + (step_y ? dx_x : '0);
        nx      = cur_x_reg + (step_x ? (x_neg_reg ? MINUS_ONE : ONE) : '0);
        ny      = cur_y_reg + (step_y ? (y_neg_reg ? MINUS_ONE : ONE) : '0);
    end

    // window test and address
    always_comb
    begin
        x_ok   = !cur_x_reg[CB-1] && (CMPB'($unsigned(cur_x_reg)) < CMPB'(win.width));
        y_ok   = !cur_y_reg[CB-1] && (CMPB'($unsigned(cur_y_reg)) < CMPB'(win.height));
        in_win = x_ok && y_ok;
        prod   = $unsigned(cur_y_reg) * win.width;
        addr   = AB'(prod) + AB'($unsigned(cur_x_reg));
    end

    always_comb
    begin
        result.produce            = (item.command == bls_pkg::CMD_STEP);
        result.item.emitted       = !at_goal;
        result.item.pixel_x       = at_goal ? '0 : cur_x_reg;
        result.item.pixel_y       = at_goal ? '0 : cur_y_reg;
        result.item.in_window     = !at_goal && in_win;
        result.item.pixel_address = (!at_goal && in_win) ? addr : '0;
        result.item.last_pixel    = !at_goal && (nx == goal_x_reg) && (ny == goal_y_reg);
    end

    always_comb
    begin
        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        goal_x_next = goal_x_reg;
        goal_y_next = goal_y_reg;
        abs_dx_next = abs_dx_reg;
        abs_dy_next = abs_dy_reg;
        err_next    = err_reg;
        x_neg_next  = x_neg_reg;
        y_neg_next  = y_neg_reg;
        if (take)
        begin
            case (item.command)
                bls_pkg::CMD_LOAD:
                begin
                    cur_x_next  = item.start_x;
                    cur_y_next  = item.start_y;
                    goal_x_next = item.end_x;
                    goal_y_next = item.end_y;
                    abs_dx_next = abs_dx_load;
                    abs_dy_next = abs_dy_load;
                    err_next    = EB'(abs_dx_load) - EB'(abs_dy_load);
                    x_neg_next  = dx_full[DB-1] || (dx_full == '0);
                    y_neg_next  = dy_full[DB-1] || (dy_full == '0);
                end
                bls_pkg::CMD_STEP:
                begin
                    if (!at_goal)
                    begin
                        cur_x_next = nx;
                        cur_y_next = ny;
                        err_next   = err_w[EB-1:0];
                    end
                end
                default:
                begin
                    cur_x_next = cur_x_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg  <= '0;
            cur_y_reg  <= '0;
            goal_x_reg <= '0;
            goal_y_reg <= '0;
            abs_dx_reg <= '0;
            abs_dy_reg <= '0;
            err_reg    <= '0;
            x_neg_reg  <= 1'b0;
            y_neg_reg  <= 1'b0;
        end
        else
        begin
            cur_x_reg  <= cur_x_next;
            cur_y_reg  <= cur_y_next;
            goal_x_reg <= goal_x_next;
            goal_y_reg <= goal_y_next;
            abs_dx_reg <= abs_dx_next;
            abs_dy_reg <= abs_dy_next;
            err_reg    <= err_next;
            x_neg_reg  <= x_neg_next;
            y_neg_reg  <= y_neg_next;
        end
    end

endmodule

`default_nettype wire
